### rtl/core/ptdt_pkg.sv
`default_nettype none

package ptdt_pkg;

    // table size default, handed down from the top level
    localparam int TABLE_DEPTH_DEF = 256;

    localparam int TILE_ROWS = 8;
    localparam int ROW_W     = 16;
    localparam int TILE_W    = TILE_ROWS * ROW_W;

    localparam logic [2:0] ROW_LAST = 3'(TILE_ROWS - 1);

    // item kinds carried in tuser
    localparam logic KIND_PIXELS  = 1'b0;
    localparam logic KIND_PRELOAD = 1'b1;

    // stream widths, whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic row_wr;        // write the accepted row into the row buffer
        logic search_start;  // clear the search pointer and compare stage
        logic search_run;    // step the search through the table
        logic take_hit;      // capture the matching index as the result
        logic append;        // append the buffered tile, or flag full
        logic out_load;      // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic hit;       // compare stage matches the buffered tile
        logic miss_end;  // last stored tile compared without a match
        logic empty;     // no tiles stored
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

### rtl/core/ptdt_ram.sv
`default_nettype none

module ptdt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/ptdt_ctrl.sv
`default_nettype none

module ptdt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_kind,
    input  wire logic [2:0]       i_row,
    input  wire ptdt_pkg::t_stat  i_stat,
    output logic                  o_s_tready,
    output ptdt_pkg::t_cmd        o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_APPEND = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.row_wr = i_s_tvalid;
                if (i_s_tvalid && i_row == ptdt_pkg::ROW_LAST) begin
                    if (i_kind == ptdt_pkg::KIND_PIXELS && !i_stat.empty) begin
                        o_cmd.search_start = 1'b1;
                        n_state            = ST_SEARCH;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end
            end
            ST_SEARCH: begin
                o_cmd.search_run = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_stat.miss_end) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/ptdt_dp.sv
`default_nettype none

module ptdt_dp #(
    parameter int TABLE_DEPTH = ptdt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ptdt_pkg::t_cmd                 i_cmd,
    input  wire logic                           i_kind,
    input  wire logic [2:0]                     i_row,
    input  wire logic [15:0]                    i_pixels,
    input  wire logic [15:0]                    i_plane_bytes,
    output ptdt_pkg::t_stat                     o_stat,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [ptdt_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // split eight 2-bit pixels into plane 0 (high byte) and plane 1 (low byte)
    function automatic logic [15:0] split_row(input logic [15:0] px);
        logic [7:0] p0;
        logic [7:0] p1;
        for (int i = 0; i < 8; i++) begin
            p0[7-i] = px[14-2*i];
            p1[7-i] = px[15-2*i];
        end
        return {p0, p1};
    endfunction

    logic [ptdt_pkg::ROW_W-1:0]  r_rows [ptdt_pkg::TILE_ROWS];
    logic [ptdt_pkg::TILE_W-1:0] w_tile;
    logic [ptdt_pkg::TILE_W-1:0] w_rdata;

    logic [CW-1:0] r_total;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_cmp_idx;
    logic          r_cmp_valid;
    logic          w_issue;
    logic          w_eq;
    logic          w_full;
    logic          w_we;

    logic [IW-1:0] r_res_idx;
    logic          r_res_new;
    logic          r_res_full;

    logic                          r_out_valid;
    logic [ptdt_pkg::M_TDATA_W-1:0] r_out_data;

    logic [IW+7:0] w_idx_ext;
    logic [CW+8:0] w_cnt_ext;

    always_comb begin
        for (int r = 0; r < ptdt_pkg::TILE_ROWS; r++) begin
            w_tile[r*ptdt_pkg::ROW_W +: ptdt_pkg::ROW_W] = r_rows[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            r_rows[i_row] <= (i_kind == ptdt_pkg::KIND_PRELOAD) ? i_plane_bytes
                                                                : split_row(i_pixels);
        end
    end

    assign w_full  = !(r_total < CW'(TABLE_DEPTH));
    assign w_issue = i_cmd.search_run && (r_addr < r_total);
    assign w_we    = i_cmd.append && !w_full;
    assign w_eq    = (w_rdata == w_tile);

    ptdt_ram #(
        .WIDTH (ptdt_pkg::TILE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_total[IW-1:0]),
        .i_wdata (w_tile),
        .i_re    (w_issue),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // search pointer and one compare stage behind the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.search_start) begin
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.search_run) begin
            r_cmp_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_start) begin
            r_addr <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + CW'(1);
        end
        if (w_issue) begin
            r_cmp_idx <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_we) begin
            r_total <= r_total + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_hit) begin
            r_res_idx  <= r_cmp_idx[IW-1:0];
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end else if (i_cmd.append) begin
            if (w_full) begin
                r_res_idx  <= IW'(TABLE_DEPTH - 1);
                r_res_new  <= 1'b0;
                r_res_full <= 1'b1;
            end else begin
                r_res_idx  <= r_total[IW-1:0];
                r_res_new  <= 1'b1;
                r_res_full <= 1'b0;
            end
        end
    end

    assign w_idx_ext = {8'b0, r_res_idx};
    assign w_cnt_ext = {9'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {5'b0, w_cnt_ext[8:0], r_res_full, r_res_new, w_idx_ext[7:0]};
        end
    end

    assign o_stat.hit      = r_cmp_valid && w_eq;
    assign o_stat.miss_end = r_cmp_valid && !w_eq && (r_cmp_idx + CW'(1) == r_total);
    assign o_stat.empty    = (r_total == '0);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(TABLE_DEPTH))
        else $error("tile count above table size");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append && w_full) |=> $stable(r_total))
        else $error("tile count moved on a dropped tile");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.hit |-> (r_cmp_idx < r_total))
        else $error("match reported beyond stored tiles");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result overwrote a pending beat");
`endif

endmodule

`default_nettype wire

### rtl/core/planar_tile_dedup_table.sv
// 8x8 tile deduplicator for 2-bit planar graphics. Each slave beat carries one tile row,
// either as eight 2-bit pixels (tuser 0, pixel 0 in bits 15:14) or as two ready-made plane
// bytes (tuser 1, plane 0 high). Rows land in a row buffer by their row number; a beat for
// row 7 closes the tile. A pixel tile is looked up against the stored table in index order
// and the first exact match returns its index; a miss, or any preload tile, is appended.
// With the table full the tile is dropped, table_full is set and the last index is given.
// One master beat follows each row-7 beat. After a row beat other than row 7 the block
// stays ready for the next beat. A closing beat makes the block busy while it searches:
// the table is one tile (128 bits) per ram word, and the search, stopping at a match,
// reads and compares one stored tile per cycle on the single read port. Rows of the next
// tile are accepted while a result still waits on the master side; a closing beat that
// finds the previous result still waiting holds the input until that result leaves. The
// tile store has no reset; only entries below the stored count are ever read.
`default_nettype none

module planar_tile_dedup_table #(
    parameter int TABLE_DEPTH = ptdt_pkg::TABLE_DEPTH_DEF   // table size, 16 to 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side: one tile row per beat
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // row [2:0], pixels [18:3], plane_bytes [34:19], zero [39:35]
    input  wire logic [ptdt_pkg::S_TDATA_W-1:0] i_s_tdata,
    // kind [0]
    input  wire logic                           i_s_tuser,
    // master side: one result per closed tile
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tile_index [7:0], was_new [8], table_full [9], stored_count [18:10], zero [23:19]
    output logic [ptdt_pkg::M_TDATA_W-1:0]      o_m_tdata
);

    ptdt_pkg::t_cmd  w_cmd;
    ptdt_pkg::t_stat w_stat;

    logic [2:0]  w_row;
    logic [15:0] w_pixels;
    logic [15:0] w_plane_bytes;

    // unpack the slave beat
    assign w_row         = i_s_tdata[2:0];
    assign w_pixels      = i_s_tdata[18:3];
    assign w_plane_bytes = i_s_tdata[34:19];

    // sequencer: accept rows, run the search, append, hand off the result
    ptdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_row      (w_row),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // row buffer, tile store, search compare and output register
    ptdt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_kind        (i_s_tuser),
        .i_row         (w_row),
        .i_pixels      (w_pixels),
        .i_plane_bytes (w_plane_bytes),
        .o_stat        (w_stat),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TILES      = ptdt_pkg::TABLE_DEPTH_DEF;
    localparam int STALL_MAX  = 5000;  // cycles with work pending and no beat moving
    localparam int HOLD_AT    = 12;    // result count at which the long back-pressure starts
    localparam int HOLD_LEN   = 400;   // cycles the result side stays not ready

    // one row beat as the slave side sees it
    typedef struct packed {
        logic        kind;
        logic [2:0]  row;
        logic [15:0] pixels;
        logic [15:0] planes;
    } t_row_item;

    // result beat, laid out as in tdata from the top bit down
    typedef struct packed {
        logic [8:0] count;
        logic       full;
        logic       fresh;
        logic [7:0] index;
    } t_tile_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [ptdt_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic                           i_s_tuser = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [ptdt_pkg::M_TDATA_W-1:0] o_m_tdata;

    always #5 i_clk = ~i_clk;

    planar_tile_dedup_table #(
        .TABLE_DEPTH (TILES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // row beats waiting for the driver, and results the table should give
    t_row_item    row_q[$];
    t_tile_result tile_results_q[$];

    // mirror of the tile table: row r of a tile sits in bits r*16 +: 16
    logic [127:0] tile_tab [TILES];
    logic [127:0] buf_tile;
    int           tile_cnt = 0;

    int err_cnt = 0;
    int items_queued = 0;
    int rows_taken = 0;
    int results_seen = 0;
    int n_hit = 0, n_new = 0, n_full = 0, n_preload = 0;

    // pixel row to plane word: pixel bit 0 into plane 0 (high byte), bit 1 into plane 1
    function automatic logic [15:0] pixels_to_planes(input logic [15:0] px);
        logic [7:0] p0, p1;
        for (int i = 0; i < 8; i++) begin
            p0[7-i] = px[14-2*i];
            p1[7-i] = px[15-2*i];
        end
        return {p0, p1};
    endfunction

    // inverse, used to send a known plane word as a pixel beat
    function automatic logic [15:0] planes_to_pixels(input logic [15:0] w);
        logic [15:0] px;
        for (int i = 0; i < 8; i++) begin
            px[14-2*i] = w[15-i];
            px[15-2*i] = w[7-i];
        end
        return px;
    endfunction

    // expected behavior for one accepted row beat
    function automatic void dedup_row(input t_row_item it);
        t_tile_result res;
        bit           found;
        found = 1'b0;
        res   = '0;
        buf_tile[it.row*16 +: 16] = (it.kind == ptdt_pkg::KIND_PRELOAD)
                                    ? it.planes : pixels_to_planes(it.pixels);
        if (it.row != ptdt_pkg::ROW_LAST)
            return;
        // only pixel tiles are looked up, first match wins
        if (it.kind == ptdt_pkg::KIND_PIXELS) begin
            for (int t = 0; t < tile_cnt && !found; t++) begin
                if (tile_tab[t] == buf_tile) begin
                    found     = 1'b1;
                    res.index = 8'(t);
                end
            end
        end else begin
            n_preload++;
        end
        if (found) begin
            n_hit++;
        end else if (tile_cnt < TILES) begin
            tile_tab[tile_cnt] = buf_tile;
            tile_cnt++;
            res.fresh = 1'b1;
            res.index = 8'(tile_cnt - 1);
            n_new++;
        end else begin
            // table full: tile dropped, last index reported
            res.full  = 1'b1;
            res.index = 8'(TILES - 1);
            n_full++;
        end
        res.count = 9'(tile_cnt);
        tile_results_q.push_back(res);
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // ---------------- driver ----------------
    t_row_item on_bus;
    int        s_gap = 0;
    bit        s_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            s_gap      <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                dedup_row(on_bus);
                rows_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (s_gap > 0) begin
                    s_gap      <= s_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (row_q.size() != 0) begin
                    on_bus = row_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {5'b0, on_bus.planes, on_bus.pixels, on_bus.row};
                    i_s_tuser  <= on_bus.kind;
                    if ($urandom_range(0, 29) == 0)
                        s_calm = !s_calm;
                    s_gap <= draw_gap(s_calm);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    t_tile_result mon_got, mon_want;
    int           m_wait = 0;
    int           m_next;
    bit           m_calm = 1'b0;

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            m_wait     <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            mon_got = t_tile_result'(o_m_tdata[18:0]);
            if (tile_results_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, got tdata %h",
                         $time, o_m_tdata);
                err_cnt++;
            end else begin
                mon_want = tile_results_q.pop_front();
                check_field("tile_index", mon_want.index, mon_got.index);
                check_field("was_new", mon_want.fresh, mon_got.fresh);
                check_field("table_full", mon_want.full, mon_got.full);
                check_field("stored_count", mon_want.count, mon_got.count);
            end
            results_seen++;
            if ($urandom_range(0, 29) == 0)
                m_calm = !m_calm;
            // one long hold so the block fills up and stalls its input
            m_next = (results_seen == HOLD_AT) ? HOLD_LEN : draw_gap(m_calm);
            i_m_tready <= (m_next == 0);
            m_wait     <= m_next;
        end else if (m_wait > 0) begin
            m_wait     <= m_wait - 1;
            i_m_tready <= (m_wait == 1);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ---------------- watchdog ----------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (row_q.size() == 0 && !i_s_tvalid && tile_results_q.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_MAX);
        $display("%0t: no beat moved for %0d cycles", $time, STALL_MAX);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- stimulus ----------------
    // word is the pixel row for a pixel beat, the plane word for a preload beat
    task automatic push_row(input logic kind, input logic [2:0] row, input logic [15:0] word);
        t_row_item it;
        it.kind   = kind;
        it.row    = row;
        it.pixels = (kind == ptdt_pkg::KIND_PIXELS) ? word : 16'($urandom);
        it.planes = (kind == ptdt_pkg::KIND_PRELOAD) ? word : 16'($urandom);
        row_q.push_back(it);
        items_queued++;
    endtask

    function automatic logic close_kind();
        return ($urandom_range(0, 7) == 0) ? ptdt_pkg::KIND_PRELOAD
                                           : ptdt_pkg::KIND_PIXELS;
    endfunction

    // full tile: rows 0..6 in order or shuffled, sometimes with mixed kinds, then row 7
    task automatic send_tile(input logic [127:0] tile, input logic closer);
        int          order [7];
        int          j, tmp;
        logic        k;
        bit          mixed;
        logic [15:0] word;
        mixed = ($urandom_range(0, 3) == 0);
        for (int r = 0; r < 7; r++)
            order[r] = r;
        if ($urandom_range(0, 1)) begin
            for (int r = 6; r > 0; r--) begin
                j        = $urandom_range(0, r);
                tmp      = order[r];
                order[r] = order[j];
                order[j] = tmp;
            end
        end
        for (int r = 0; r < 7; r++) begin
            k    = mixed ? 1'($urandom) : ptdt_pkg::KIND_PIXELS;
            word = tile[order[r]*16 +: 16];
            push_row(k, 3'(order[r]),
                     (k == ptdt_pkg::KIND_PRELOAD) ? word : planes_to_pixels(word));
        end
        word = tile[112 +: 16];
        push_row(closer, ptdt_pkg::ROW_LAST,
                 (closer == ptdt_pkg::KIND_PRELOAD) ? word : planes_to_pixels(word));
    endtask

    // random tile, either any bits or whole-byte planes over a few rows
    function automatic logic [127:0] fresh_tile();
        logic [127:0] t;
        if ($urandom_range(0, 1)) begin
            t = {$urandom, $urandom, $urandom, $urandom};
        end else begin
            t = '0;
            for (int r = 4; r < 8; r++)
                t[r*16 +: 16] = {{8{1'($urandom)}}, {8{1'($urandom)}}};
        end
        return t;
    endfunction

    // mix of repeats of stored tiles, new tiles, near misses, bare closes and stray rows;
    // runs in zero time while the table mirror is settled
    task automatic run_batch(input int n);
        int           stop;
        logic [127:0] t;
        stop = items_queued + n;
        while (items_queued < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_tile(tile_tab[$urandom_range(0, tile_cnt - 1)], close_kind());
                end
                4, 5, 6: begin
                    send_tile(fresh_tile(), close_kind());
                end
                7: begin
                    t = tile_tab[$urandom_range(0, tile_cnt - 1)];
                    t[$urandom_range(0, 127)] ^= 1'b1;
                    send_tile(t, ptdt_pkg::KIND_PIXELS);
                end
                8: begin
                    push_row(1'($urandom), ptdt_pkg::ROW_LAST, 16'($urandom));
                end
                default: begin
                    repeat ($urandom_range(1, 3))
                        push_row(1'($urandom), 3'($urandom_range(0, 6)), 16'($urandom));
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (row_q.size() != 0 || i_s_tvalid || tile_results_q.size() != 0);
    endtask

    initial begin
        int need, preloads;

        // zero tile, then its preloaded copy, then a lookup that must hit the first one
        for (int r = 0; r < 8; r++)
            push_row(ptdt_pkg::KIND_PIXELS, 3'(r), 16'h0000);
        push_row(ptdt_pkg::KIND_PRELOAD, ptdt_pkg::ROW_LAST, 16'h0000);
        push_row(ptdt_pkg::KIND_PIXELS, ptdt_pkg::ROW_LAST, 16'h0000);
        // all-ones tile written in reverse row order
        for (int r = 6; r >= 0; r--)
            push_row(ptdt_pkg::KIND_PIXELS, 3'(r), 16'hFFFF);
        push_row(ptdt_pkg::KIND_PIXELS, ptdt_pkg::ROW_LAST, 16'hFFFF);
        // two rows changed with mixed kinds, the rest kept from before
        push_row(ptdt_pkg::KIND_PRELOAD, 3'd3, 16'hFF00);
        push_row(ptdt_pkg::KIND_PIXELS, 3'd5, 16'hAAAA);
        push_row(ptdt_pkg::KIND_PIXELS, ptdt_pkg::ROW_LAST, 16'hFFFF);
        // back to all ones: hit at a nonzero index
        push_row(ptdt_pkg::KIND_PIXELS, 3'd3, 16'hFFFF);
        push_row(ptdt_pkg::KIND_PRELOAD, 3'd5, 16'hFFFF);
        push_row(ptdt_pkg::KIND_PIXELS, ptdt_pkg::ROW_LAST, 16'hFFFF);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        repeat (5) begin
            run_batch(25);
            wait_drained();
        end

        // fill the table with one-beat preload tiles, a lookup now and then, past full
        need     = TILES - tile_cnt;
        preloads = 0;
        while (preloads < need + 4) begin
            if ($urandom_range(0, 15) == 0) begin
                push_row(ptdt_pkg::KIND_PIXELS, ptdt_pkg::ROW_LAST, 16'($urandom));
            end else begin
                push_row(ptdt_pkg::KIND_PRELOAD, ptdt_pkg::ROW_LAST, 16'($urandom));
                preloads++;
            end
        end
        wait_drained();

        // full table: hits anywhere up to the last index, misses and preloads dropped
        repeat (3) begin
            run_batch(25);
            wait_drained();
        end

        repeat (TILES + 40) @(posedge i_clk);

        $display("covered %0d row beats and %0d results: %0d hits, %0d appended, %0d dropped",
                 rows_taken, results_seen, n_hit, n_new, n_full);
        $display("closes by preload %0d, tiles held at the end %0d of %0d",
                 n_preload, tile_cnt, TILES);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
